@@ rtl/core/qft_pkg.sv @@
`default_nettype none

package qft_pkg;

	// special byte values
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	// configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DELIM0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DELIM1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DELIM2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DELIM3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DQ_EN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SQ_EN  = 3'd5;

	// scanner modes
	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_TOKEN = 2'd1,
		MODE_SKIP  = 2'd2
	} scan_mode_t;

	// one result transaction
	typedef struct packed {
		logic       emit_backslash;
		logic       byte_valid;
		logic [7:0] out_byte;
		logic       token_end;
	} qft_result_t;

endpackage

`default_nettype wire

@@ rtl/core/qft_in_if.sv @@
`default_nettype none

interface qft_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_string;

	modport source (output valid, output in_byte, output end_of_string, input ready);
	modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

@@ rtl/core/qft_out_if.sv @@
`default_nettype none

interface qft_out_if;
	logic       valid;
	logic       ready;
	logic       emit_backslash;
	logic       byte_valid;
	logic [7:0] out_byte;
	logic       token_end;

	modport source (output valid, output emit_backslash, output byte_valid, output out_byte,
		output token_end, input ready);
	modport sink (input valid, input emit_backslash, input byte_valid, input out_byte,
		input token_end, output ready);
endinterface

`default_nettype wire

@@ rtl/core/qft_cfg_if.sv @@
`default_nettype none

interface qft_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [qft_pkg::CFG_IDX_W-1:0]    index;
	logic [qft_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/quoted_field_tokenizer_top.sv @@
`default_nettype none

// Quoted field tokenizer: takes one byte per input transaction and returns exactly one
// result transaction for it through a result register. A new byte is taken in every cycle
// while the result side keeps up; input ready drops only while the result register holds
// an untaken result. The delimiter set is a 256-bit map written as four 64-bit registers,
// and double and single quote handling each have an enable. A backslash that is not the
// last byte of a string is held for one byte and released through emit_backslash with the
// next result unless it escapes an enabled quote. Configuration writes are always taken.
module quoted_field_tokenizer_top (
	input  wire          clk,
	input  wire          arst_n,
	qft_in_if.sink       in_ch,
	qft_out_if.source    out_ch,
	qft_cfg_if.sink      cfg_ch
);

	// configuration registers
	logic [63:0] delim_map_q [4];
	logic        dq_en_q;
	logic        sq_en_q;

	// scanner state
	qft_pkg::scan_mode_t mode_q, mode_d;
	logic                in_double_q, in_double_d;
	logic                in_single_q, in_single_d;
	logic                held_bs_q, held_bs_d;

	// result register
	logic                 out_valid_q;
	qft_pkg::qft_result_t res_q, res_d;

	logic in_acc;
	logic last;
	logic is_delim;
	logic tok_mode;
	logic d_eff, s_eff, h_eff;
	logic isdq, issq, is_bs;
	logic skip_del, start_del, tok_del;

	// handshakes
	assign cfg_ch.ready = 1'b1;
	assign in_ch.ready  = !out_valid_q || out_ch.ready;
	assign in_acc       = in_ch.valid && in_ch.ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_map_q[0] <= '0;
			delim_map_q[1] <= '0;
			delim_map_q[2] <= '0;
			delim_map_q[3] <= '0;
			dq_en_q        <= 1'b1;
			sq_en_q        <= 1'b0;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index) inside
				qft_pkg::CFG_DELIM0, qft_pkg::CFG_DELIM1,
				qft_pkg::CFG_DELIM2, qft_pkg::CFG_DELIM3: begin
					delim_map_q[cfg_ch.index[1:0]] <= cfg_ch.data;
				end
				qft_pkg::CFG_DQ_EN: begin
					dq_en_q <= cfg_ch.data[0];
				end
				qft_pkg::CFG_SQ_EN: begin
					sq_en_q <= cfg_ch.data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// byte classification
	assign last      = in_ch.end_of_string;
	assign is_delim  = delim_map_q[in_ch.in_byte[7:6]][in_ch.in_byte[5:0]];
	assign tok_mode  = (mode_q == qft_pkg::MODE_TOKEN);
	assign d_eff     = tok_mode && in_double_q;
	assign s_eff     = tok_mode && in_single_q;
	assign h_eff     = tok_mode && held_bs_q;
	assign isdq      = dq_en_q && (in_ch.in_byte == qft_pkg::CH_DQUOTE);
	assign issq      = sq_en_q && (in_ch.in_byte == qft_pkg::CH_SQUOTE);
	assign is_bs     = (in_ch.in_byte == qft_pkg::CH_BSLASH);
	assign skip_del  = (mode_q == qft_pkg::MODE_SKIP) && is_delim;
	assign start_del = (mode_q == qft_pkg::MODE_START) && is_delim;
	assign tok_del   = !skip_del && !start_del && !d_eff && !s_eff && is_delim;

	// next state
	always_comb begin
		mode_d      = mode_q;
		in_double_d = in_double_q;
		in_single_d = in_single_q;
		held_bs_d   = held_bs_q;
		if (skip_del) begin
			if (last) begin
				mode_d      = qft_pkg::MODE_START;
				in_double_d = 1'b0;
				in_single_d = 1'b0;
				held_bs_d   = 1'b0;
			end
		end else if (start_del) begin
			mode_d      = last ? qft_pkg::MODE_START : qft_pkg::MODE_SKIP;
			in_double_d = 1'b0;
			in_single_d = 1'b0;
			held_bs_d   = 1'b0;
		end else if (tok_del) begin
			mode_d      = last ? qft_pkg::MODE_START : qft_pkg::MODE_SKIP;
			in_double_d = 1'b0;
			in_single_d = 1'b0;
			held_bs_d   = 1'b0;
		end else begin
			mode_d      = qft_pkg::MODE_TOKEN;
			in_double_d = d_eff;
			in_single_d = s_eff;
			held_bs_d   = h_eff;
			if (isdq || issq) begin
				// escaped quote clears the hold, plain quote toggles its flag
				if (h_eff) begin
					held_bs_d = 1'b0;
				end else if (isdq) begin
					in_double_d = !d_eff;
				end else begin
					in_single_d = !s_eff;
				end
			end else if (is_bs && !last) begin
				held_bs_d = 1'b1;
			end else begin
				held_bs_d = 1'b0;
			end
			if (last) begin
				mode_d      = qft_pkg::MODE_START;
				in_double_d = 1'b0;
				in_single_d = 1'b0;
				held_bs_d   = 1'b0;
			end
		end
	end

	// result fields
	always_comb begin
		res_d = '0;
		if (skip_del) begin
			res_d = '0;
		end else if (start_del) begin
			res_d.token_end = 1'b1;
		end else if (tok_del) begin
			res_d.emit_backslash = h_eff;
			res_d.token_end      = 1'b1;
		end else begin
			if (isdq || issq) begin
				if (h_eff) begin
					res_d.byte_valid = 1'b1;
					res_d.out_byte   = in_ch.in_byte;
				end
			end else if (is_bs && !last) begin
				res_d.emit_backslash = h_eff;
			end else begin
				res_d.emit_backslash = h_eff;
				res_d.byte_valid     = 1'b1;
				res_d.out_byte       = in_ch.in_byte;
			end
			res_d.token_end = last;
		end
	end

	// scanner state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= qft_pkg::MODE_START;
			in_double_q <= 1'b0;
			in_single_q <= 1'b0;
			held_bs_q   <= 1'b0;
		end else if (in_acc) begin
			mode_q      <= mode_d;
			in_double_q <= in_double_d;
			in_single_q <= in_single_d;
			held_bs_q   <= held_bs_d;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_q <= res_d;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.emit_backslash = res_q.emit_backslash;
	assign out_ch.byte_valid     = res_q.byte_valid;
	assign out_ch.out_byte       = res_q.out_byte;
	assign out_ch.token_end      = res_q.token_end;

`ifndef ASSERT_OFF
	// a held backslash only exists inside a token
	a_held_in_token: assert property (@(posedge clk) disable iff (!arst_n)
		held_bs_q |-> (mode_q == qft_pkg::MODE_TOKEN))
		else $error("held backslash outside token mode");

	// quote flags are clear while skipping a delimiter run
	a_skip_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == qft_pkg::MODE_SKIP) |-> (!in_double_q && !in_single_q && !held_bs_q))
		else $error("quote state left over in skip mode");

	// end of string brings the scanner back to string start
	a_eos_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_ch.end_of_string) |=>
		(mode_q == qft_pkg::MODE_START && !in_double_q && !in_single_q && !held_bs_q))
		else $error("state not cleared after end of string");

	// a released backslash must have been held before this byte
	a_emit_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (!res_q.emit_backslash || $past(held_bs_q)))
		else $error("backslash released without being held");

	// no byte value without byte_valid
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_q.byte_valid) |-> (res_q.out_byte == 8'h00))
		else $error("out_byte set without byte_valid");
`endif

endmodule

`default_nettype wire
